### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks on the block clock, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SOFC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SOFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Expression never holds.
`define SOFC_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

### sv/sofc_pkg.sv
// ----------------------------------------------------------------------------
// sofc_pkg
// Shared sizes, types and constants of the subflow order counter table.
// ----------------------------------------------------------------------------
package sofc_pkg;

    localparam int TABLE_ENTRIES = 128;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_W         = 32;
    localparam int MARK_W        = 32;
    localparam int ENTRY_W       = KEY_W + MARK_W;

    localparam logic [MARK_W-1:0] MARK_FIRST = MARK_W'(1);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic               wr_en;
        logic [IDX_W-1:0]   wr_addr;
        logic [ENTRY_W-1:0] wr_data;
        logic               rd_en;
        logic [IDX_W-1:0]   rd_addr;
    } t_mem_req;

    typedef struct packed {
        logic              valid;
        logic              marked;
        logic [MARK_W-1:0] mark;
        logic              is_primary;
        logic              table_full;
    } t_result;

endpackage

### sv/sofc_ram.sv
// ----------------------------------------------------------------------------
// sofc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sofc_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/sofc_ctrl.sv
// ----------------------------------------------------------------------------
// sofc_ctrl
// Scan sequencer: walks the filled part of the table, bumps a hit, or appends or flags a full table.
// ----------------------------------------------------------------------------
module sofc_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_kind,
    input  logic                           i_is_multipath,
    input  logic [sofc_pkg::KEY_W-1:0]     i_token,
    input  logic [sofc_pkg::ENTRY_W-1:0]   i_rd_data,
    output logic                           o_busy,
    output sofc_pkg::t_mem_req             o_mem_req,
    output sofc_pkg::t_result              o_res
);
    import sofc_pkg::*;
    `include "assert_macros.svh"

    t_state            r_state,   n_state;
    logic [KEY_W-1:0]  r_token,   n_token;
    logic [CNT_W-1:0]  r_fill,    n_fill;
    logic [CNT_W-1:0]  r_rd_idx,  n_rd_idx;
    logic              r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx, n_cmp_idx;

    logic              rd_go;
    logic              hit;
    logic [KEY_W-1:0]  rd_key;
    logic [MARK_W-1:0] rd_count;
    logic [MARK_W-1:0] new_count;

    assign rd_key    = i_rd_data[ENTRY_W-1:MARK_W];
    assign rd_count  = i_rd_data[MARK_W-1:0];
    assign new_count = rd_count + MARK_FIRST;
    assign rd_go     = (r_rd_idx < r_fill);
    assign hit       = r_cmp_vld && (rd_key == r_token);
    assign o_busy    = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_token   <= n_token;
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
    end

    always_comb begin
        n_state   = r_state;
        n_token   = r_token;
        n_fill    = r_fill;
        n_rd_idx  = r_rd_idx;
        n_cmp_vld = 1'b0;
        n_cmp_idx = r_cmp_idx;
        o_mem_req = '0;
        o_res     = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_kind && i_is_multipath) begin
                        n_token  = i_token;
                        n_rd_idx = '0;
                        n_state  = ST_SCAN;
                    end else begin
                        // ignored event: all-zero result right away
                        o_res.valid = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                // issue next read while comparing the previous one
                o_mem_req.rd_en   = rd_go;
                o_mem_req.rd_addr = r_rd_idx[IDX_W-1:0];
                n_cmp_vld         = rd_go;
                n_cmp_idx         = r_rd_idx[IDX_W-1:0];
                if (rd_go) begin
                    n_rd_idx = r_rd_idx + CNT_W'(1);
                end
                if (hit) begin
                    o_mem_req.wr_en   = 1'b1;
                    o_mem_req.wr_addr = r_cmp_idx;
                    o_mem_req.wr_data = {r_token, new_count};
                    o_res.valid       = 1'b1;
                    o_res.marked      = 1'b1;
                    o_res.mark        = new_count;
                    o_res.is_primary  = (new_count == MARK_FIRST);
                    n_cmp_vld         = 1'b0;
                    n_state           = ST_IDLE;
                end else if (!r_cmp_vld && !rd_go) begin
                    // miss over the whole filled range: append or flag full
                    o_res.valid      = 1'b1;
                    o_res.marked     = 1'b1;
                    o_res.mark       = MARK_FIRST;
                    o_res.is_primary = 1'b1;
                    if (r_fill != CNT_W'(TABLE_ENTRIES)) begin
                        o_mem_req.wr_en   = 1'b1;
                        o_mem_req.wr_addr = r_fill[IDX_W-1:0];
                        o_mem_req.wr_data = {r_token, MARK_FIRST};
                        n_fill            = r_fill + CNT_W'(1);
                    end else begin
                        o_res.table_full = 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `SOFC_ASSERT_NEVER(a_fill_bound, r_fill > CNT_W'(TABLE_ENTRIES), "fill count overflow")
    `SOFC_ASSERT_IMPL(a_wr_in_scan, o_mem_req.wr_en, r_state == ST_SCAN, "write outside scan")
    `SOFC_ASSERT_IMPL(a_cmp_in_fill, r_cmp_vld, {1'b0, r_cmp_idx} < r_fill, "compare past fill")
    `SOFC_ASSERT_NEXT(a_scan_ends, o_res.valid && (r_state == ST_SCAN), r_state == ST_IDLE,
        "scan did not end after result")

endmodule

### sv/subflow_order_counter_table.sv
// ----------------------------------------------------------------------------
// subflow_order_counter_table
// Per-token connect counter: looks a token up in a table, counts or appends.
// ----------------------------------------------------------------------------
// Timing: an ignored event is answered straight from idle; a counted event walks
//   the stored tokens from index 0, one entry per cycle through the RAM read port,
//   and ends at the first hit or after the last stored token. Results are registered.
// Throughput: one item at a time; a counted event holds busy until its result
//   cycle, an ignored event leaves busy low. Results strobe one cycle, no stall.
// Reset: synchronous, active low; empties the table (fill count to zero).
module subflow_order_counter_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_kind,
    input  logic                       i_is_multipath,
    input  logic [sofc_pkg::KEY_W-1:0] i_token,
    output logic                       o_valid,
    output logic                       o_marked,
    output logic [sofc_pkg::MARK_W-1:0] o_mark,
    output logic                       o_is_primary,
    output logic                       o_table_full
);
    import sofc_pkg::*;

    t_mem_req           mem_req;
    t_result            res;
    logic [ENTRY_W-1:0] rd_data;
    logic               r_valid;
    t_result            r_res;

    sofc_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_kind         (i_kind),
        .i_is_multipath (i_is_multipath),
        .i_token        (i_token),
        .i_rd_data      (rd_data),
        .o_busy         (busy),
        .o_mem_req      (mem_req),
        .o_res          (res)
    );

    sofc_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_req.wr_en),
        .i_wr_addr (mem_req.wr_addr),
        .i_wr_data (mem_req.wr_data),
        .i_rd_en   (mem_req.rd_en),
        .i_rd_addr (mem_req.rd_addr),
        .o_rd_data (rd_data)
    );

    // register the result item for a clean one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= res;
    end

    assign o_valid      = r_valid;
    assign o_marked     = r_res.marked;
    assign o_mark       = r_res.mark;
    assign o_is_primary = r_res.is_primary;
    assign o_table_full = r_res.table_full;

endmodule

### tb/sv/subflow_order_counter_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subflow_order_counter_table_tb
// Drives connection events through the start/busy handshake and checks every
// strobed mark against a table model kept alongside: ignored events, first
// and repeated tokens, a full table, and long random runs with idle gaps.
// ----------------------------------------------------------------------------
module subflow_order_counter_table_tb;
    import sofc_pkg::*;

    localparam int RUN_LIMIT = 1000000;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic              marked;
        logic [MARK_W-1:0] mark;
        logic              is_primary;
        logic              table_full;
    } t_mark_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_kind = 1'b0;
    logic              i_is_multipath = 1'b0;
    logic [KEY_W-1:0]  i_token = '0;
    logic              o_valid;
    logic              o_marked;
    logic [MARK_W-1:0] o_mark;
    logic              o_is_primary;
    logic              o_table_full;

    // Token table as the block should hold it: filled from index 0 upward
    logic [KEY_W-1:0]  tbl_key [TABLE_ENTRIES];
    logic [MARK_W-1:0] tbl_count [TABLE_ENTRIES];
    int                tbl_fill = 0;

    t_mark_result pending_marks[$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    bit           start_high = 1'b0;
    bit           steady = 1'b0;

    subflow_order_counter_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_is_multipath (i_is_multipath),
        .i_token        (i_token),
        .o_valid        (o_valid),
        .o_marked       (o_marked),
        .o_mark         (o_mark),
        .o_is_primary   (o_is_primary),
        .o_table_full   (o_table_full)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_mark_result count_event(input logic kind, input logic mp,
                                                 input logic [KEY_W-1:0] token);
        t_mark_result res;
        int           hit;
        res = '0;
        hit = -1;
        if (kind && mp) begin
            res.marked = 1'b1;
            for (int i = 0; i < tbl_fill && hit < 0; i++)
                if (tbl_key[i] == token)
                    hit = i;
            if (hit >= 0) begin
                tbl_count[hit] = tbl_count[hit] + MARK_FIRST;
                res.mark = tbl_count[hit];
            end else begin
                if (tbl_fill < TABLE_ENTRIES) begin
                    tbl_key[tbl_fill]   = token;
                    tbl_count[tbl_fill] = MARK_FIRST;
                    tbl_fill++;
                end else begin
                    res.table_full = 1'b1;
                end
                res.mark = MARK_FIRST;
            end
            res.is_primary = (res.mark == MARK_FIRST);
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [MARK_W-1:0] want,
                                 input logic [MARK_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
            $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    always @(posedge i_clk) begin : result_check
        t_mark_result want;
        if (i_rst_n && o_valid) begin
            if (pending_marks.size() == 0) begin
                flag_mismatch("o_valid with no item pending", '0, o_mark);
            end else begin
                want = pending_marks.pop_front();
                if (o_marked !== want.marked)
                    flag_mismatch("o_marked", MARK_W'(want.marked), MARK_W'(o_marked));
                if (o_mark !== want.mark)
                    flag_mismatch("o_mark", want.mark, o_mark);
                if (o_is_primary !== want.is_primary)
                    flag_mismatch("o_is_primary", MARK_W'(want.is_primary),
                                  MARK_W'(o_is_primary));
                if (o_table_full !== want.table_full)
                    flag_mismatch("o_table_full", MARK_W'(want.table_full),
                                  MARK_W'(o_table_full));
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Drop start if it is still high; send_event skips this when the next item follows with no gap
    task automatic idle_start();
        if (start_high) begin
            start <= 1'b0;
            start_high = 1'b0;
        end
    endtask

    task automatic send_event(input logic kind, input logic mp, input logic [KEY_W-1:0] token);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            idle_start();
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_kind         <= kind;
        i_is_multipath <= mp;
        i_token        <= token;
        start_high = 1'b1;
        do @(posedge i_clk); while (busy);
        pending_marks.push_back(count_event(kind, mp, token));
    endtask

    task automatic wait_drained();
        idle_start();
        while (pending_marks.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_stored_token();
        int top;
        if (tbl_fill == 0)
            return $urandom;
        top = (tbl_fill > 8) ? 7 : tbl_fill - 1;
        if ($urandom_range(0, 9) < 6)
            return tbl_key[$urandom_range(0, top)];
        return tbl_key[$urandom_range(0, tbl_fill - 1)];
    endfunction

    task automatic send_random_event(input int fresh_pct);
        int   r;
        logic kind;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            // at least one of kind / multipath low
            kind = 1'($urandom_range(0, 1));
            send_event(kind, kind ? 1'b0 : 1'($urandom_range(0, 1)),
                       ($urandom_range(0, 1) == 1) ? pick_stored_token() : $urandom);
        end else if (r < 15 + fresh_pct) begin
            send_event(1'b1, 1'b1, $urandom);
        end else begin
            send_event(1'b1, 1'b1, pick_stored_token());
        end
    endtask

    task automatic test_ignored_events();
        send_event(1'b0, 1'b0, '0);
        send_event(1'b0, 1'b1, '1);
        send_event(1'b1, 1'b0, '1);
        send_event(1'b0, 1'b1, 32'h8000_0001);
    endtask

    task automatic test_new_and_repeat();
        send_event(1'b1, 1'b1, '0);
        send_event(1'b1, 1'b1, '1);
        send_event(1'b1, 1'b1, 32'h5555_5555);
        send_event(1'b1, 1'b1, 32'hAAAA_AAAA);
        send_event(1'b1, 1'b1, '0);
        send_event(1'b1, 1'b1, '1);
        send_event(1'b1, 1'b1, '0);
        // ignored events on a stored token must leave its count alone
        send_event(1'b1, 1'b0, '0);
        send_event(1'b0, 1'b1, '0);
        send_event(1'b1, 1'b1, '0);
        send_event(1'b1, 1'b1, 32'hAAAA_AAAA);
        send_event(1'b1, 1'b1, 32'h0000_0001);
    endtask

    task automatic test_random_counts(input int n_items);
        for (int i = 0; i < n_items; i++) begin
            if (i % 64 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (i % 150 == 149)
                wait_drained();
            send_random_event(12);
        end
        steady = 1'b0;
    endtask

    task automatic test_fill_table();
        while (tbl_fill < TABLE_ENTRIES)
            send_event(1'b1, 1'b1, $urandom);
        send_event(1'b1, 1'b1, $urandom);
        send_event(1'b1, 1'b1, $urandom);
        send_event(1'b1, 1'b1, tbl_key[0]);
        send_event(1'b1, 1'b1, tbl_key[TABLE_ENTRIES - 1]);
        send_event(1'b1, 1'b1, tbl_key[TABLE_ENTRIES - 1]);
    endtask

    task automatic test_random_full(input int n_items);
        for (int i = 0; i < n_items; i++) begin
            if (i % 64 == 0)
                steady = ($urandom_range(0, 3) == 0);
            send_random_event(25);
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_ignored_events();
        test_new_and_repeat();
        test_random_counts(600);
        wait_drained();
        test_fill_table();
        test_random_full(450);
        wait_drained();
        repeat (TABLE_ENTRIES + 16) @(posedge i_clk);
        if (mismatch_count == 0 && pending_marks.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/sofc_pkg.sv
sv/sofc_ram.sv
sv/sofc_ctrl.sv
sv/subflow_order_counter_table.sv
tb/sv/subflow_order_counter_table_tb.sv
